>>> rtl/ddm_pkg.sv
// Shared types, constants and helper functions of the differential drive mixer.
`timescale 1ns / 1ps
`default_nettype none

package ddm_pkg;

  localparam int MAX_PWM_BITS = 12;
  localparam int MIN_PWM_BITS = 8;
  localparam int STICK_W      = 16;
  localparam int SPEED_W      = 12;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  // Divider sizing: |v - lo| < 2^16 times 2P < 2^13 stays below 2^29.
  localparam int NUM_W = 29;
  localparam int DEN_W = 16;

  // Pipeline stage indexes.
  localparam int STG_DIFF = 0;
  localparam int STG_MUL  = 1;
  localparam int STG_DIV0 = 2;
  localparam int STG_MAP  = NUM_W + 2;
  localparam int STG_OUT  = NUM_W + 3;
  localparam int DEPTH    = NUM_W + 4;

  typedef enum logic [1:0] {
    KIND_ARCADE = 2'd0,
    KIND_TANK   = 2'd1,
    KIND_STOP   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    DIR_FORWARD = 2'd0,
    DIR_REVERSE = 2'd1,
    DIR_STOP    = 2'd2
  } dir_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FWD_MIN  = 3'd0,
    CFG_FWD_MAX  = 3'd1,
    CFG_LAT_MIN  = 3'd2,
    CFG_LAT_MAX  = 3'd3,
    CFG_PWM_BITS = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [STICK_W-1:0] lo;
    logic signed [STICK_W-1:0] hi;
  } rng_t;

  // PWM maximum: 2^bits - 1 with bits clamped into the supported range.
  function automatic logic [SPEED_W-1:0] pwm_max(input logic [3:0] bits);
    logic [3:0]         b;
    logic [SPEED_W:0]   one_sh;
    b = bits;
    if (b < 4'(MIN_PWM_BITS)) b = 4'(MIN_PWM_BITS);
    if (b > 4'(MAX_PWM_BITS)) b = 4'(MAX_PWM_BITS);
    one_sh = (SPEED_W+1)'(1) << b;
    return SPEED_W'(one_sh - (SPEED_W+1)'(1));
  endfunction

  // Saturate a wide signed value to the 16-bit stick range.
  function automatic logic signed [STICK_W-1:0] sat16(input logic signed [30:0] v);
    if (v > 31'sd32767) return 16'sh7fff;
    if (v < -31'sd32768) return 16'sh8000;
    return v[STICK_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/ddm_if.sv
// Valid/ready stream interfaces for the mixer's sample and result channels.
`timescale 1ns / 1ps
`default_nettype none

interface ddm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] lateral_or_left;
  logic [15:0] forward_or_right;
  logic        inverted;

  modport source (output valid, kind, lateral_or_left, forward_or_right, inverted,
                  input ready);
  modport sink   (input valid, kind, lateral_or_left, forward_or_right, inverted,
                  output ready);
endinterface

interface ddm_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] left_duty;
  logic [1:0]  left_direction;
  logic [11:0] right_duty;
  logic [1:0]  right_direction;

  modport source (output valid, left_duty, left_direction, right_duty,
                  right_direction, input ready);
  modport sink   (input valid, left_duty, left_direction, right_duty,
                  right_direction, output ready);
endinterface

`default_nettype wire

>>> rtl/ddm_lane.sv
// One stick lane: offset, scale, pipelined restoring divide and re-center.
`timescale 1ns / 1ps
`default_nettype none

module ddm_lane
  import ddm_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic [DEPTH-1:0]          ld_i,
  input  wire logic signed [STICK_W-1:0] stick_i,
  input  wire logic                      sel_i,
  input  wire rng_t                      rng0_i,
  input  wire rng_t                      rng1_i,
  input  wire logic [SPEED_W-1:0]        p_i,
  output logic signed [STICK_W-1:0]      mapped_o
);

  // Range-derived divisor terms, refreshed every cycle from configuration.
  logic [DEN_W-1:0] den_q [2];
  logic             neg_q [2];
  logic             empty_q [2];
  logic signed [STICK_W:0] rd0, rd1;

  assign rd0 = {rng0_i.hi[STICK_W-1], rng0_i.hi} - {rng0_i.lo[STICK_W-1], rng0_i.lo};
  assign rd1 = {rng1_i.hi[STICK_W-1], rng1_i.hi} - {rng1_i.lo[STICK_W-1], rng1_i.lo};

  always_ff @(posedge clk_i) begin
    den_q[0]   <= rd0[STICK_W] ? DEN_W'(-rd0) : DEN_W'(rd0);
    den_q[1]   <= rd1[STICK_W] ? DEN_W'(-rd1) : DEN_W'(rd1);
    neg_q[0]   <= rd0[STICK_W];
    neg_q[1]   <= rd1[STICK_W];
    empty_q[0] <= (rd0 == '0);
    empty_q[1] <= (rd1 == '0);
  end

  // Offset stage.
  logic signed [STICK_W-1:0] lo;
  logic signed [STICK_W:0]   diff;
  logic [DEN_W-1:0]          a_mag_q;
  logic                      a_ns_q, a_sel_q;

  assign lo   = sel_i ? rng1_i.lo : rng0_i.lo;
  assign diff = {stick_i[STICK_W-1], stick_i} - {lo[STICK_W-1], lo};

  always_ff @(posedge clk_i) begin
    if (ld_i[STG_DIFF]) begin
      a_mag_q <= diff[STICK_W] ? DEN_W'(-diff) : DEN_W'(diff);
      a_ns_q  <= diff[STICK_W];
      a_sel_q <= sel_i;
    end
  end

  // Scale stage: |v - lo| * 2P.
  logic [NUM_W-1:0] b_num_q;
  logic             b_ns_q, b_sel_q;

  always_ff @(posedge clk_i) begin
    if (ld_i[STG_MUL]) begin
      b_num_q <= NUM_W'(a_mag_q) * NUM_W'({p_i, 1'b0});
      b_ns_q  <= a_ns_q;
      b_sel_q <= a_sel_q;
    end
  end

  // Restoring divider, one quotient bit per stage; the numerator shifts out
  // as the quotient shifts in.
  logic [DEN_W-1:0] rem_q [NUM_W];
  logic [NUM_W-1:0] nq_q  [NUM_W];
  logic             ns_q  [NUM_W];
  logic             sel_q [NUM_W];

  for (genvar j = 0; j < NUM_W; j++) begin : g_div
    logic [DEN_W-1:0] rem_in;
    logic [NUM_W-1:0] nq_in;
    logic             ns_in, sel_in;
    logic [DEN_W:0]   t, t_sub;
    logic             ge;

    if (j == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = b_num_q;
      assign ns_in  = b_ns_q;
      assign sel_in = b_sel_q;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign nq_in  = nq_q[j-1];
      assign ns_in  = ns_q[j-1];
      assign sel_in = sel_q[j-1];
    end

    assign t     = {rem_in, nq_in[NUM_W-1]};
    assign t_sub = t - {1'b0, den_q[sel_in]};
    assign ge    = (t >= {1'b0, den_q[sel_in]});

    always_ff @(posedge clk_i) begin
      if (ld_i[STG_DIV0 + j]) begin
        rem_q[j] <= ge ? t_sub[DEN_W-1:0] : t[DEN_W-1:0];
        nq_q[j]  <= {nq_in[NUM_W-2:0], ge};
        ns_q[j]  <= ns_in;
        sel_q[j] <= sel_in;
      end
    end
  end

  // Re-center: apply the quotient sign, subtract P and saturate.
  logic [NUM_W-1:0]  q;
  logic              f_sel, qsign;
  logic signed [30:0] qe, pe, s;
  logic signed [STICK_W-1:0] c_q;

  assign q     = nq_q[NUM_W-1];
  assign f_sel = sel_q[NUM_W-1];
  assign qsign = ns_q[NUM_W-1] ^ neg_q[f_sel];
  assign qe    = 31'(q);
  assign pe    = 31'(p_i);
  assign s     = qsign ? -(qe + pe) : (qe - pe);

  always_ff @(posedge clk_i) begin
    if (ld_i[STG_MAP]) begin
      c_q <= empty_q[f_sel] ? '0 : sat16(s);
    end
  end

  assign mapped_o = c_q;

endmodule

`default_nettype wire

>>> rtl/ddm_mix.sv
// Merge stage: combines the two mapped sticks per mode and forms motor outputs.
`timescale 1ns / 1ps
`default_nettype none

module ddm_mix
  import ddm_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      ld_i,
  input  wire logic [1:0]                kind_i,
  input  wire logic                      flip_i,
  input  wire logic signed [STICK_W-1:0] m0_i,
  input  wire logic signed [STICK_W-1:0] m1_i,
  input  wire logic [SPEED_W-1:0]        p_i,
  output logic [SPEED_W-1:0]             left_duty_o,
  output logic [1:0]                     left_dir_o,
  output logic [SPEED_W-1:0]             right_duty_o,
  output logic [1:0]                     right_dir_o
);

  function automatic logic [SPEED_W-1:0] speed_of(input logic signed [STICK_W-1:0] v,
                                                  input logic [SPEED_W-1:0] p);
    logic [STICK_W:0] mag;
    mag = v[STICK_W-1] ? (STICK_W+1)'(-{v[STICK_W-1], v}) : (STICK_W+1)'(v);
    return (mag > (STICK_W+1)'(p)) ? p : SPEED_W'(mag);
  endfunction

  logic signed [STICK_W-1:0] plus, minus, left, right;
  logic                      stop;

  assign plus  = sat16(31'(m1_i) + 31'(m0_i));
  assign minus = sat16(31'(m1_i) - 31'(m0_i));

  always_comb begin
    left  = '0;
    right = '0;
    stop  = 1'b0;
    case (kind_e'(kind_i))
      KIND_ARCADE: begin
        left  = flip_i ? minus : plus;
        right = flip_i ? plus : minus;
      end
      KIND_TANK: begin
        left  = flip_i ? m1_i : m0_i;
        right = flip_i ? m0_i : m1_i;
      end
      default: begin
        stop = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      if (stop) begin
        left_duty_o  <= '0;
        right_duty_o <= '0;
        left_dir_o   <= DIR_STOP;
        right_dir_o  <= DIR_STOP;
      end else begin
        left_duty_o  <= speed_of(left, p_i);
        right_duty_o <= speed_of(right, p_i);
        left_dir_o   <= left[STICK_W-1] ? DIR_REVERSE : DIR_FORWARD;
        right_dir_o  <= right[STICK_W-1] ? DIR_REVERSE : DIR_FORWARD;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/differential_drive_mixer_top.sv
// Top level of the differential drive mixer: configuration, lanes, merge and flow control.
`timescale 1ns / 1ps
`default_nettype none

// Differential drive mixer. Each sample beat carries a mode (arcade, tank or
// stop), two signed stick values and an upside-down flag; each result beat
// carries a duty magnitude and a direction for the left and right motor.
// Throughput is one sample per clock while out_if.ready does not hold the
// output back. The pipe has 33 register stages: an offset stage, a 16x13
// multiply stage, 29 stages of a restoring divider (one quotient bit per
// stage, which sets the depth), a re-center/saturate stage and the mixing
// output register. Two identical lanes map the two sticks in parallel; the
// merge stage then mixes them per mode. Stages advance independently, so
// bubbles collapse and a sample is taken even while a finished result waits
// at the output, as long as a stage is free. Configuration registers are
// forward_min (0), forward_max (1), lateral_min (2), lateral_max (3) and
// pwm_bits (4); write them only while no sample is in flight.

module differential_drive_mixer_top
  import ddm_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  ddm_in_if.sink                     in_if,
  ddm_out_if.source                  out_if,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  // Configuration registers.
  rng_t       fwd_rng_q, lat_rng_q;
  logic [3:0] pwm_bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_rng_q  <= '{lo: -16'sd512, hi: 16'sd511};
      lat_rng_q  <= '{lo: -16'sd512, hi: 16'sd511};
      pwm_bits_q <= 4'd8;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FWD_MIN:  fwd_rng_q.lo <= cfg_wdata_i;
        CFG_FWD_MAX:  fwd_rng_q.hi <= cfg_wdata_i;
        CFG_LAT_MIN:  lat_rng_q.lo <= cfg_wdata_i;
        CFG_LAT_MAX:  lat_rng_q.hi <= cfg_wdata_i;
        CFG_PWM_BITS: pwm_bits_q   <= cfg_wdata_i[3:0];
        default: begin
        end
      endcase
    end
  end

  logic [SPEED_W-1:0] p;
  assign p = pwm_max(pwm_bits_q);

  // Flow control: a stage loads when it is empty or its content moves on.
  logic [DEPTH-1:0] vld_q, vld_d, ld;

  always_comb begin
    ld[DEPTH-1] = !vld_q[DEPTH-1] || out_if.ready;
    for (int k = DEPTH - 2; k >= 0; k--) begin
      ld[k] = !vld_q[k] || ld[k+1];
    end
    vld_d[0] = ld[0] ? in_if.valid : vld_q[0];
    for (int k = 1; k < DEPTH; k++) begin
      vld_d[k] = ld[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_if.ready  = ld[0];
  assign out_if.valid = vld_q[DEPTH-1];

  // Mode and flip travel alongside the lanes up to the merge stage.
  logic [1:0] kind_q [STG_OUT];
  logic       flip_q [STG_OUT];

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      kind_q[0] <= in_if.kind;
      flip_q[0] <= in_if.inverted;
    end
    for (int k = 1; k < STG_OUT; k++) begin
      if (ld[k]) begin
        kind_q[k] <= kind_q[k-1];
        flip_q[k] <= flip_q[k-1];
      end
    end
  end

  // Lane 0 maps the lateral stick (arcade) or left stick (tank, forward range).
  logic                      lane0_sel;
  logic signed [STICK_W-1:0] m0, m1;

  assign lane0_sel = (kind_e'(in_if.kind) == KIND_ARCADE);

  ddm_lane u_lane0 (
    .clk_i    (clk_i),
    .ld_i     (ld),
    .stick_i  (in_if.lateral_or_left),
    .sel_i    (lane0_sel),
    .rng0_i   (fwd_rng_q),
    .rng1_i   (lat_rng_q),
    .p_i      (p),
    .mapped_o (m0)
  );

  // Lane 1 always maps on the forward range.
  ddm_lane u_lane1 (
    .clk_i    (clk_i),
    .ld_i     (ld),
    .stick_i  (in_if.forward_or_right),
    .sel_i    (1'b0),
    .rng0_i   (fwd_rng_q),
    .rng1_i   (lat_rng_q),
    .p_i      (p),
    .mapped_o (m1)
  );

  ddm_mix u_mix (
    .clk_i        (clk_i),
    .ld_i         (ld[STG_OUT]),
    .kind_i       (kind_q[STG_OUT-1]),
    .flip_i       (flip_q[STG_OUT-1]),
    .m0_i         (m0),
    .m1_i         (m1),
    .p_i          (p),
    .left_duty_o  (out_if.left_duty),
    .left_dir_o   (out_if.left_direction),
    .right_duty_o (out_if.right_duty),
    .right_dir_o  (out_if.right_direction)
  );

endmodule

`default_nettype wire
